// File: sv/w2sh_pkg.sv
package w2sh_pkg;

    // Field widths
    localparam int POS_W      = 16;
    localparam int WGT_W      = 16;
    localparam int INV_W      = 16;
    localparam int NP_W       = 9;
    localparam int IDX_W      = 8;
    localparam int RBIN_W     = 5;
    localparam int STAT_W     = 3;
    localparam int DENS_W     = 32;
    localparam int TOT_W      = 40;
    localparam int SUM_W      = 32;

    // Q3.12 times Q8.8 gives 20 fraction bits; Q8.8 times 256 over Q8.8 gives Q16.16
    localparam int BIN_FRAC   = 20;
    localparam int NORM_SH    = 8;

    localparam int HALF_BINS_DEF = 16;

    // Register port: two 32-bit registers at byte stride 4
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int REG_STRIDE = 4;
    localparam logic REG_INV_BIN_WIDTH = 1'b0;
    localparam logic REG_NUM_PARTICLES = 1'b1;
    localparam logic [INV_W-1:0] INV_RESET = 16'd1280;
    localparam logic [NP_W-1:0]  NP_RESET  = 9'd2;

    typedef enum logic [1:0] {
        OP_ACC   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SPARE = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_ACC     = 3'd0,
        ST_DROP    = 3'd1,
        ST_READ    = 3'd2,
        ST_CLEARED = 3'd3,
        ST_ZERO    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_ACC,
        BK_RDATA,
        BK_MUL,
        BK_DSTART,
        BK_DIV,
        BK_CLEAR
    } back_state_t;

    // Classified transaction passed from front to back
    typedef struct packed {
        op_t              op;
        logic             hit;
        logic             first_sel;
        logic [WGT_W-1:0] weight;
    } item_ctrl_t;

    typedef struct packed {
        logic init_busy;
        logic pop;
    } back_stat_t;

endpackage

// File: sv/w2sh_ram.sv
module w2sh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/w2sh_fifo.sv
module w2sh_fifo #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] ent_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;

    // Two-entry queue
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = ent_reg[rd_ptr_reg];
    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);

endmodule

// File: sv/w2sh_div.sv
module w2sh_div #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 40,
    parameter int Q_W   = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic             last;

    // One restoring step per cycle; quotient bits shift in behind the dividend
    always_comb begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
        last  = (cnt_reg == CNT_W'(NUM_W - 1));

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            num_next  = num;
            den_next  = den;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_next  = {num_reg[NUM_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            busy_next = !last;
            done_next = last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    // Saturate quotients that do not fit the result width
    assign quo  = (|num_reg[NUM_W-1:Q_W]) ? '1 : num_reg[Q_W-1:0];
    assign done = done_reg;

endmodule

// File: sv/w2sh_front.sv
module w2sh_front #(
    parameter int HALF_BINS = w2sh_pkg::HALF_BINS_DEF
) (
    input  logic [1:0]                                s_operation,
    input  logic signed [w2sh_pkg::POS_W-1:0]         s_pos_x,
    input  logic signed [w2sh_pkg::POS_W-1:0]         s_pos_y,
    input  logic [w2sh_pkg::WGT_W-1:0]                s_weight,
    input  logic [w2sh_pkg::IDX_W-1:0]                s_particle_index,
    input  logic [w2sh_pkg::RBIN_W-1:0]               s_bin_x,
    input  logic [w2sh_pkg::RBIN_W-1:0]               s_bin_y,
    input  logic [w2sh_pkg::INV_W-1:0]                inv_bin_width,
    input  logic [w2sh_pkg::NP_W-1:0]                 num_particles,
    output w2sh_pkg::item_ctrl_t                      ctrl,
    output logic [$clog2(4*HALF_BINS*HALF_BINS)-1:0]  bin_addr
);

    import w2sh_pkg::*;

    localparam int GRID   = 2 * HALF_BINS;
    localparam int CELL_W = $clog2(GRID * GRID);
    localparam int PROD_W = POS_W + INV_W + 1;
    localparam int Q_W    = PROD_W - BIN_FRAC;
    localparam int B_W    = Q_W + 1;
    localparam logic signed [B_W-1:0] HB_S   = B_W'(HALF_BINS);
    localparam logic signed [B_W-1:0] GRID_S = B_W'(GRID);

    logic signed [PROD_W-1:0] prod_x, prod_y;
    logic signed [B_W-1:0]    bx, by;
    logic                     acc_in, rd_in;
    logic [CELL_W-1:0]        acc_cell, rd_cell;
    op_t                      op_in;

    // Bin the position: floor of the Q3.12 x Q8.8 product, then recentre
    always_comb begin
        prod_x = s_pos_x * $signed({1'b0, inv_bin_width});
        prod_y = s_pos_y * $signed({1'b0, inv_bin_width});
        bx     = $signed({prod_x[PROD_W-1], prod_x[PROD_W-1:BIN_FRAC]}) + HB_S;
        by     = $signed({prod_y[PROD_W-1], prod_y[PROD_W-1:BIN_FRAC]}) + HB_S;
        acc_in = (bx >= 0) && (bx < GRID_S) && (by >= 0) && (by < GRID_S);
        acc_cell = CELL_W'($unsigned(bx)) * CELL_W'(GRID) + CELL_W'($unsigned(by));
        rd_in  = (8'(s_bin_x) < 8'(GRID)) && (8'(s_bin_y) < 8'(GRID));
        rd_cell = CELL_W'(s_bin_x) * CELL_W'(GRID) + CELL_W'(s_bin_y);
    end

    // Classify the transaction; the spare code reads
    always_comb begin
        op_in          = op_t'(s_operation);
        ctrl.weight    = s_weight;
        ctrl.first_sel = (s_particle_index < num_particles[NP_W-1:1]);
        unique case (op_in) inside
            OP_ACC: begin
                ctrl.op  = OP_ACC;
                ctrl.hit = acc_in;
                bin_addr = acc_cell;
            end
            OP_CLEAR: begin
                ctrl.op  = OP_CLEAR;
                ctrl.hit = 1'b0;
                bin_addr = rd_cell;
            end
            OP_READ, OP_SPARE: begin
                ctrl.op  = OP_READ;
                ctrl.hit = rd_in;
                bin_addr = rd_cell;
            end
        endcase
    end

endmodule

// File: sv/w2sh_back.sv
module w2sh_back #(
    parameter int HALF_BINS = w2sh_pkg::HALF_BINS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic [w2sh_pkg::INV_W-1:0]                inv_bin_width,
    input  w2sh_pkg::item_ctrl_t                      head_ctrl,
    input  logic [$clog2(4*HALF_BINS*HALF_BINS)-1:0]  head_cell,
    input  logic                                      fifo_empty,
    output w2sh_pkg::back_stat_t                      stat,
    input  logic                                      m_ready,
    output logic                                      m_valid,
    output logic [w2sh_pkg::STAT_W-1:0]               m_status,
    output logic [w2sh_pkg::DENS_W-1:0]               m_density_first,
    output logic [w2sh_pkg::DENS_W-1:0]               m_density_second,
    output logic [w2sh_pkg::TOT_W-1:0]                m_total_weight
);

    import w2sh_pkg::*;

    localparam int GRID   = 2 * HALF_BINS;
    localparam int DEPTH  = GRID * GRID;
    localparam int CELL_W = $clog2(DEPTH);
    localparam int PROD_W = SUM_W + INV_W;
    localparam int NUM_W  = PROD_W + NORM_SH;

    back_state_t        state_reg, state_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [CELL_W-1:0]  cur_cell_reg, cur_cell_next;
    logic               cur_first_reg, cur_first_next;
    logic [WGT_W-1:0]   cur_weight_reg, cur_weight_next;
    logic [CELL_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [SUM_W-1:0]   sum1_reg, sum1_next, sum2_reg, sum2_next;
    logic               sel_reg, sel_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [DENS_W-1:0]  d1_reg, d1_next;
    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg;
    logic [DENS_W-1:0]  m_d1_reg, m_d2_reg;
    logic [TOT_W-1:0]   m_total_reg;

    logic               can_pop, clr_last;
    logic               pop, re, we1, we2, div_start, div_done;
    logic [CELL_W-1:0]  raddr, waddr;
    logic [SUM_W-1:0]   wdata, rd1, rd2, old_sum, acc_sum;
    logic [SUM_W:0]     sum_wide;
    logic [TOT_W:0]     tot_wide;
    logic [TOT_W-1:0]   tot_add;
    logic [DENS_W-1:0]  quo;
    logic               emit;
    status_t            emit_status;
    logic [DENS_W-1:0]  emit_d1, emit_d2;

    w2sh_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_ram_first (
        .aclk(aclk), .we(we1), .waddr(waddr), .wdata(wdata),
        .re(re), .raddr(raddr), .rdata(rd1)
    );

    w2sh_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_ram_second (
        .aclk(aclk), .we(we2), .waddr(waddr), .wdata(wdata),
        .re(re), .raddr(raddr), .rdata(rd2)
    );

    w2sh_div #(.NUM_W(NUM_W), .DEN_W(TOT_W), .Q_W(DENS_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num({prod_reg, NORM_SH'(0)}), .den(total_reg),
        .done(div_done), .quo(quo)
    );

    // Saturating adders
    always_comb begin
        tot_wide = {1'b0, total_reg} + (TOT_W+1)'(head_ctrl.weight);
        tot_add  = tot_wide[TOT_W] ? '1 : tot_wide[TOT_W-1:0];
        old_sum  = cur_first_reg ? rd1 : rd2;
        sum_wide = {1'b0, old_sum} + (SUM_W+1)'(cur_weight_reg);
        acc_sum  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    end

    assign can_pop  = !fifo_empty && !m_valid_reg;
    assign clr_last = (clr_cnt_reg == CELL_W'(DEPTH - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_INIT: begin
                if (clr_last) state_next = BK_IDLE;
            end
            BK_IDLE: begin
                if (can_pop) begin
                    unique case (head_ctrl.op) inside
                        OP_ACC:   state_next = head_ctrl.hit ? BK_ACC : BK_IDLE;
                        OP_CLEAR: state_next = BK_CLEAR;
                        OP_READ, OP_SPARE: begin
                            state_next = (head_ctrl.hit && total_reg != '0) ?
                                         BK_RDATA : BK_IDLE;
                        end
                    endcase
                end
            end
            BK_ACC:    state_next = BK_IDLE;
            BK_RDATA:  state_next = BK_MUL;
            BK_MUL:    state_next = BK_DSTART;
            BK_DSTART: state_next = BK_DIV;
            BK_DIV: begin
                if (div_done) state_next = sel_reg ? BK_IDLE : BK_MUL;
            end
            BK_CLEAR: begin
                if (clr_last) state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and memory control per state
    always_comb begin
        pop             = 1'b0;
        re              = 1'b0;
        raddr           = head_cell;
        we1             = 1'b0;
        we2             = 1'b0;
        waddr           = cur_cell_reg;
        wdata           = acc_sum;
        div_start       = 1'b0;
        emit            = 1'b0;
        emit_status     = ST_ACC;
        emit_d1         = '0;
        emit_d2         = '0;
        total_next      = total_reg;
        cur_cell_next   = cur_cell_reg;
        cur_first_next  = cur_first_reg;
        cur_weight_next = cur_weight_reg;
        clr_cnt_next    = clr_cnt_reg;
        sum1_next       = sum1_reg;
        sum2_next       = sum2_reg;
        sel_next        = sel_reg;
        prod_next       = prod_reg;
        d1_next         = d1_reg;
        unique case (state_reg)
            BK_INIT: begin
                waddr        = clr_cnt_reg;
                wdata        = '0;
                we1          = 1'b1;
                we2          = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            BK_IDLE: begin
                if (can_pop) begin
                    pop             = 1'b1;
                    cur_cell_next   = head_cell;
                    cur_first_next  = head_ctrl.first_sel;
                    cur_weight_next = head_ctrl.weight;
                    unique case (head_ctrl.op) inside
                        OP_ACC: begin
                            total_next = tot_add;
                            if (head_ctrl.hit) begin
                                re = 1'b1;
                            end else begin
                                emit        = 1'b1;
                                emit_status = ST_DROP;
                            end
                        end
                        OP_CLEAR: begin
                            total_next   = '0;
                            clr_cnt_next = '0;
                        end
                        OP_READ, OP_SPARE: begin
                            if (total_reg == '0) begin
                                emit        = 1'b1;
                                emit_status = ST_ZERO;
                            end else if (!head_ctrl.hit) begin
                                emit        = 1'b1;
                                emit_status = ST_READ;
                            end else begin
                                re = 1'b1;
                            end
                        end
                    endcase
                end
            end
            BK_ACC: begin
                we1         = cur_first_reg;
                we2         = !cur_first_reg;
                emit        = 1'b1;
                emit_status = ST_ACC;
            end
            BK_RDATA: begin
                sum1_next = rd1;
                sum2_next = rd2;
                sel_next  = 1'b0;
            end
            BK_MUL: begin
                prod_next = (sel_reg ? sum2_reg : sum1_reg) * inv_bin_width;
            end
            BK_DSTART: begin
                div_start = 1'b1;
            end
            BK_DIV: begin
                if (div_done) begin
                    if (!sel_reg) begin
                        d1_next  = quo;
                        sel_next = 1'b1;
                    end else begin
                        emit        = 1'b1;
                        emit_status = ST_READ;
                        emit_d1     = d1_reg;
                        emit_d2     = quo;
                    end
                end
            end
            BK_CLEAR: begin
                waddr        = clr_cnt_reg;
                wdata        = '0;
                we1          = 1'b1;
                we2          = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last) begin
                    emit        = 1'b1;
                    emit_status = ST_CLEARED;
                end
            end
        endcase
        m_valid_next = emit || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_INIT;
            total_reg   <= '0;
            clr_cnt_reg <= '0;
            sel_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            clr_cnt_reg <= clr_cnt_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_cell_reg   <= cur_cell_next;
        cur_first_reg  <= cur_first_next;
        cur_weight_reg <= cur_weight_next;
        sum1_reg       <= sum1_next;
        sum2_reg       <= sum2_next;
        prod_reg       <= prod_next;
        d1_reg         <= d1_next;
        if (emit) begin
            m_status_reg <= emit_status;
            m_d1_reg     <= emit_d1;
            m_d2_reg     <= emit_d2;
            m_total_reg  <= total_next;
        end
    end

    assign stat.init_busy   = (state_reg == BK_INIT);
    assign stat.pop         = pop;
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_density_first  = m_d1_reg;
    assign m_density_second = m_d2_reg;
    assign m_total_weight   = m_total_reg;

endmodule

// File: sv/weighted_2d_split_histogram_top.sv
// Weighted 2D split histogram.
// Input channel s_*: one transaction per item (accumulate, read or clear),
// valid/ready handshake. Result channel m_*: exactly one transaction per
// input item, in order, valid/ready handshake.
// Register port (APB style, pready tied high): inv_bin_width at 0x0,
// num_particles at 0x4; write only while the block is idle.
// Sequencing: an accumulate is a memory read, then write, in the back end;
// a read that hits the grid runs the shared bit-serial divider once per
// table; a clear zeroes the tables, one table row entry a cycle.
// The front classifies and bins items into a two-entry queue, so input is
// taken while the back end works or a result waits for m_ready; a result
// sits in an output register until taken, and the back end then holds.
// Reset: synchronous, aresetn low. After release the tables are swept to
// zero, all (2*HALF_BINS)^2 entries (1024 by default), with s_ready low;
// register writes are taken throughout.
module weighted_2d_split_histogram_top #(
    parameter int HALF_BINS = w2sh_pkg::HALF_BINS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [w2sh_pkg::PADDR_W-1:0]          paddr,
    input  logic [w2sh_pkg::PDATA_W-1:0]          pwdata,
    output logic [w2sh_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready,
    // input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_operation,
    input  logic signed [w2sh_pkg::POS_W-1:0]     s_pos_x,
    input  logic signed [w2sh_pkg::POS_W-1:0]     s_pos_y,
    input  logic [w2sh_pkg::WGT_W-1:0]            s_weight,
    input  logic [w2sh_pkg::IDX_W-1:0]            s_particle_index,
    input  logic [w2sh_pkg::RBIN_W-1:0]           s_bin_x,
    input  logic [w2sh_pkg::RBIN_W-1:0]           s_bin_y,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [w2sh_pkg::STAT_W-1:0]           m_status,
    output logic [w2sh_pkg::DENS_W-1:0]           m_density_first,
    output logic [w2sh_pkg::DENS_W-1:0]           m_density_second,
    output logic [w2sh_pkg::TOT_W-1:0]            m_total_weight
);

    import w2sh_pkg::*;

    localparam int GRID   = 2 * HALF_BINS;
    localparam int CELL_W = $clog2(GRID * GRID);
    localparam int Q_ENT_W = $bits(item_ctrl_t) + CELL_W;
    localparam int REG_BIT = $clog2(REG_STRIDE);

    logic [INV_W-1:0]   inv_reg, inv_next;
    logic [NP_W-1:0]    np_reg, np_next;
    logic               cfg_wr;
    item_ctrl_t         fr_ctrl, hd_ctrl;
    logic [CELL_W-1:0]  fr_cell, hd_cell;
    logic [Q_ENT_W-1:0] q_rdata;
    logic               q_full, q_empty, push;
    back_stat_t         bk_stat;

    // Configuration registers
    always_comb begin
        cfg_wr   = psel && penable && pwrite && pready;
        inv_next = inv_reg;
        np_next  = np_reg;
        if (cfg_wr) begin
            case (paddr[REG_BIT])
                REG_INV_BIN_WIDTH: inv_next = pwdata[INV_W-1:0];
                default:           np_next  = pwdata[NP_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_reg <= INV_RESET;
            np_reg  <= NP_RESET;
        end else begin
            inv_reg <= inv_next;
            np_reg  <= np_next;
        end
    end

    always_comb begin
        case (paddr[REG_BIT])
            REG_INV_BIN_WIDTH: prdata = PDATA_W'(inv_reg);
            default:           prdata = PDATA_W'(np_reg);
        endcase
    end

    assign pready = 1'b1;

    // Front: bin and classify
    w2sh_front #(.HALF_BINS(HALF_BINS)) u_front (
        .s_operation(s_operation), .s_pos_x(s_pos_x), .s_pos_y(s_pos_y),
        .s_weight(s_weight), .s_particle_index(s_particle_index),
        .s_bin_x(s_bin_x), .s_bin_y(s_bin_y),
        .inv_bin_width(inv_reg), .num_particles(np_reg),
        .ctrl(fr_ctrl), .bin_addr(fr_cell)
    );

    assign s_ready = !q_full && !bk_stat.init_busy;
    assign push    = s_valid && s_ready;

    w2sh_fifo #(.WIDTH(Q_ENT_W)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .wdata({fr_ctrl, fr_cell}),
        .pop(bk_stat.pop), .rdata(q_rdata),
        .full(q_full), .empty(q_empty)
    );

    assign {hd_ctrl, hd_cell} = q_rdata;

    // Back: table updates, normalisation, clearing
    w2sh_back #(.HALF_BINS(HALF_BINS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .inv_bin_width(inv_reg),
        .head_ctrl(hd_ctrl), .head_cell(hd_cell), .fifo_empty(q_empty),
        .stat(bk_stat), .m_ready(m_ready), .m_valid(m_valid),
        .m_status(m_status), .m_density_first(m_density_first),
        .m_density_second(m_density_second), .m_total_weight(m_total_weight)
    );

`ifndef ASSERT_OFF
    a_no_take_during_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_stat.init_busy |-> !s_ready)
        else $error("input taken during table sweep");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_stat.pop |-> !q_empty)
        else $error("queue popped while empty");

    a_zero_total_densities: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_ZERO || m_status == ST_ACC)) |->
        (m_density_first == '0 && m_density_second == '0))
        else $error("densities nonzero outside a valid read");
`endif

endmodule
